// ----- design/tcpq_pkg.sv -----
// Package for the two-class priority queue.
// Holds the command codes, the cell shift actions and the word types of both channels.
// Has no dependencies.
package tcpq_pkg;

    typedef enum logic [1:0] {
        CMD_INSERT   = 2'd0,
        CMD_SERVE    = 2'd1,
        CMD_WITHDRAW = 2'd2,
        CMD_QUERY    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        CA_HOLD = 2'd0,
        CA_LOAD = 2'd1,
        CA_PREV = 2'd2,
        CA_NEXT = 2'd3
    } cell_act_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

    localparam int ID_W   = 16;
    localparam int AGE_W  = 8;
    localparam int SIZE_W = 5;

    localparam logic [AGE_W-1:0] THR_RESET = 8'd60;

    typedef struct packed {
        cmd_t             command;
        logic [ID_W-1:0]  person_id;
        logic [AGE_W-1:0] age;
    } in_word_t;

    typedef struct packed {
        logic              ok;
        logic [ID_W-1:0]   served_id;
        logic [AGE_W-1:0]  age_out;
        logic              full_reject;
        logic [SIZE_W-1:0] queue_size;
    } out_word_t;

endpackage

// ----- design/two_class_priority_queue.sv -----
// Two-class priority queue: a chain of slot cells kept in order, preferred entries first.
// A command is accepted in idle; it executes once no held result word is stalled, which
// registers the result word. No new command is taken before that. Acceptance registers
// the key match in every cell, and execution shifts the chain.
// Reset empties the queue at once and sets the threshold to 60; no clearing pass is needed.
// Depends on tcpq_pkg and tcpq_cell.
module two_class_priority_queue #(
    parameter int CAPACITY = 16,
    parameter int KEY_BITS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  tcpq_pkg::in_word_t         in_word,
    output logic                       out_valid,
    input  logic                       out_stall,
    output tcpq_pkg::out_word_t        out_word,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [tcpq_pkg::AGE_W-1:0] cfg_data
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    tcpq_pkg::state_t           state_reg, state_next;
    logic [tcpq_pkg::AGE_W-1:0] thr_reg, thr_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [CNT_W-1:0]           pref_reg, pref_next;
    tcpq_pkg::cmd_t             cmd_reg, cmd_next;
    logic [KEY_BITS-1:0]        key_reg, key_next;
    logic [tcpq_pkg::AGE_W-1:0] age_reg, age_next;
    logic                       out_valid_reg, out_valid_next;
    tcpq_pkg::out_word_t        out_word_reg, out_word_next;

    logic                       accept;
    logic                       exec_go;
    logic [KEY_BITS+tcpq_pkg::ID_W-1:0] in_key_wide;
    logic [KEY_BITS-1:0]        in_key;

    logic [KEY_BITS-1:0]        cell_key [CAPACITY];
    logic [tcpq_pkg::AGE_W-1:0] cell_age [CAPACITY];
    logic [CAPACITY-1:0]        used_vec;
    logic [CAPACITY-1:0]        match_vec;
    tcpq_pkg::cell_act_t        cell_act [CAPACITY];

    logic                       found;
    logic                       full;
    logic                       nonempty;
    logic                       is_pref;
    logic                       do_ins;
    logic                       do_rem;
    logic [IDX_W-1:0]           match_pos;
    logic [IDX_W-1:0]           ins_at;
    logic [IDX_W-1:0]           rem_pos;
    logic [tcpq_pkg::AGE_W-1:0] match_age;
    logic [KEY_BITS+tcpq_pkg::ID_W-1:0] served_wide;
    logic [CNT_W+tcpq_pkg::SIZE_W-1:0]  size_wide;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != tcpq_pkg::S_IDLE);
    assign cfg_ready = 1'b1;
    assign exec_go   = (state_reg == tcpq_pkg::S_EXEC) && (!out_valid_reg || !out_stall);

    assign in_key_wide = {{KEY_BITS{1'b0}}, in_word.person_id};
    assign in_key      = in_key_wide[KEY_BITS-1:0];

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            localparam logic [IDX_W-1:0] CELL_IDX = IDX_W'(gi);
            logic [KEY_BITS-1:0]        p_key, n_key;
            logic [tcpq_pkg::AGE_W-1:0] p_age, n_age;
            logic                       p_used, n_used;

            if (gi == 0)
            begin : g_first
                assign p_key  = '0;
                assign p_age  = '0;
                assign p_used = 1'b0;
            end
            else
            begin : g_mid_prev
                assign p_key  = cell_key[gi-1];
                assign p_age  = cell_age[gi-1];
                assign p_used = used_vec[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_last
                assign n_key  = '0;
                assign n_age  = '0;
                assign n_used = 1'b0;
            end
            else
            begin : g_mid_next
                assign n_key  = cell_key[gi+1];
                assign n_age  = cell_age[gi+1];
                assign n_used = used_vec[gi+1];
            end

            always_comb
            begin
                cell_act[gi] = tcpq_pkg::CA_HOLD;
                if (exec_go && do_ins)
                begin
                    if (CELL_IDX == ins_at)
                        cell_act[gi] = tcpq_pkg::CA_LOAD;
                    else if (CELL_IDX > ins_at)
                        cell_act[gi] = tcpq_pkg::CA_PREV;
                end
                else if (exec_go && do_rem && (CELL_IDX >= rem_pos))
                begin
                    cell_act[gi] = tcpq_pkg::CA_NEXT;
                end
            end

            tcpq_cell #(
                .KEY_W (KEY_BITS)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .act       (cell_act[gi]),
                .cmp_en    (accept),
                .cmp_key   (in_key),
                .new_key   (key_reg),
                .new_age   (age_reg),
                .prev_key  (p_key),
                .prev_age  (p_age),
                .prev_used (p_used),
                .next_key  (n_key),
                .next_age  (n_age),
                .next_used (n_used),
                .key       (cell_key[gi]),
                .age       (cell_age[gi]),
                .used      (used_vec[gi]),
                .match     (match_vec[gi])
            );
        end
    endgenerate

    always_comb
    begin
        match_pos = '0;
        match_age = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (match_vec[i])
            begin
                match_pos = match_pos | IDX_W'(i);
                match_age = match_age | cell_age[i];
            end
        end
    end

    assign found    = |match_vec;
    assign full     = (cnt_reg >= CNT_W'(CAPACITY));
    assign nonempty = (cnt_reg != '0);
    assign is_pref  = (age_reg >= thr_reg);
    assign ins_at   = is_pref ? pref_reg[IDX_W-1:0] : cnt_reg[IDX_W-1:0];
    assign rem_pos  = (cmd_reg == tcpq_pkg::CMD_SERVE) ? '0 : match_pos;
    assign do_ins   = (cmd_reg == tcpq_pkg::CMD_INSERT) && !found && !full;
    assign do_rem   = ((cmd_reg == tcpq_pkg::CMD_SERVE) && nonempty)
                   || ((cmd_reg == tcpq_pkg::CMD_WITHDRAW) && found);

    assign served_wide = {{tcpq_pkg::ID_W{1'b0}}, cell_key[0]};

    always_comb
    begin
        state_next     = state_reg;
        thr_next       = (cfg_valid && cfg_ready) ? cfg_data : thr_reg;
        cnt_next       = cnt_reg;
        pref_next      = pref_reg;
        cmd_next       = accept ? in_word.command : cmd_reg;
        key_next       = accept ? in_key : key_reg;
        age_next       = accept ? in_word.age : age_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_word_next  = out_word_reg;

        case (state_reg)
            tcpq_pkg::S_IDLE:
            begin
                if (accept)
                    state_next = tcpq_pkg::S_EXEC;
            end
            tcpq_pkg::S_EXEC:
            begin
                if (exec_go)
                    state_next = tcpq_pkg::S_IDLE;
            end
            default:
            begin
                state_next = tcpq_pkg::S_IDLE;
            end
        endcase

        if (exec_go)
        begin
            if (do_ins)
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (is_pref)
                    pref_next = pref_reg + CNT_W'(1);
            end
            else if (do_rem)
            begin
                cnt_next = cnt_reg - CNT_W'(1);
                if (CNT_W'(rem_pos) < pref_reg)
                    pref_next = pref_reg - CNT_W'(1);
            end
        end

        size_wide = {{tcpq_pkg::SIZE_W{1'b0}}, cnt_next};

        if (exec_go)
        begin
            out_valid_next            = 1'b1;
            out_word_next.ok          = 1'b0;
            out_word_next.served_id   = '0;
            out_word_next.age_out     = '0;
            out_word_next.full_reject = 1'b0;
            out_word_next.queue_size  = size_wide[tcpq_pkg::SIZE_W-1:0];
            case (cmd_reg)
                tcpq_pkg::CMD_INSERT:
                begin
                    out_word_next.ok          = do_ins;
                    out_word_next.full_reject = !found && full;
                end
                tcpq_pkg::CMD_SERVE:
                begin
                    out_word_next.ok = nonempty;
                    if (nonempty)
                        out_word_next.served_id = served_wide[tcpq_pkg::ID_W-1:0];
                end
                tcpq_pkg::CMD_WITHDRAW:
                begin
                    out_word_next.ok = found;
                end
                tcpq_pkg::CMD_QUERY:
                begin
                    out_word_next.ok = found;
                    if (found)
                        out_word_next.age_out = match_age;
                end
                default:
                begin
                    out_word_next.ok = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tcpq_pkg::S_IDLE;
            thr_reg       <= tcpq_pkg::THR_RESET;
            cnt_reg       <= '0;
            pref_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            thr_reg       <= thr_next;
            cnt_reg       <= cnt_next;
            pref_reg      <= pref_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        key_reg      <= key_next;
        age_reg      <= age_next;
        out_word_reg <= out_word_next;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // The preferred class never outgrows the whole queue.
    a_pref_le_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        pref_reg <= cnt_reg)
        else $error("preferred count exceeds entry count");

    // Occupied cells always number exactly the entry count.
    a_used_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(used_vec) == 32'(cnt_reg))
        else $error("occupied cells disagree with entry count");

    // Keys are unique, so at most one cell matches during execution.
    a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tcpq_pkg::S_EXEC) |-> $onehot0(match_vec))
        else $error("more than one cell matches the key");

    // A result word appears only from an execution cycle.
    a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == tcpq_pkg::S_EXEC))
        else $error("result word without execution");

    // The entry count changes only after an execution step.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(exec_go) |-> $stable(cnt_reg))
        else $error("entry count changed outside execution");

endmodule

// ----- design/tcpq_cell.sv -----
// One slot of the queue chain: key, age and occupancy, with a registered key match.
// Loads a new entry or takes the entry of its left or right neighbor.
// Depends on tcpq_pkg.
module tcpq_cell #(
    parameter int KEY_W = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  tcpq_pkg::cell_act_t          act,
    input  logic                         cmp_en,
    input  logic [KEY_W-1:0]             cmp_key,
    input  logic [KEY_W-1:0]             new_key,
    input  logic [tcpq_pkg::AGE_W-1:0]   new_age,
    input  logic [KEY_W-1:0]             prev_key,
    input  logic [tcpq_pkg::AGE_W-1:0]   prev_age,
    input  logic                         prev_used,
    input  logic [KEY_W-1:0]             next_key,
    input  logic [tcpq_pkg::AGE_W-1:0]   next_age,
    input  logic                         next_used,
    output logic [KEY_W-1:0]             key,
    output logic [tcpq_pkg::AGE_W-1:0]   age,
    output logic                         used,
    output logic                         match
);

    logic [KEY_W-1:0]           key_reg, key_next;
    logic [tcpq_pkg::AGE_W-1:0] age_reg, age_next;
    logic                       used_reg, used_next;
    logic                       match_reg, match_next;

    always_comb
    begin
        key_next  = key_reg;
        age_next  = age_reg;
        used_next = used_reg;
        case (act)
            tcpq_pkg::CA_LOAD:
            begin
                key_next  = new_key;
                age_next  = new_age;
                used_next = 1'b1;
            end
            tcpq_pkg::CA_PREV:
            begin
                key_next  = prev_key;
                age_next  = prev_age;
                used_next = prev_used;
            end
            tcpq_pkg::CA_NEXT:
            begin
                key_next  = next_key;
                age_next  = next_age;
                used_next = next_used;
            end
            default:
            begin
                key_next  = key_reg;
                age_next  = age_reg;
                used_next = used_reg;
            end
        endcase
        match_next = cmp_en ? (used_reg && (key_reg == cmp_key)) : match_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg  <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            used_reg  <= used_next;
            match_reg <= match_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        age_reg <= age_next;
    end

    assign key   = key_reg;
    assign age   = age_reg;
    assign used  = used_reg;
    assign match = match_reg;

endmodule
